@@ src/mpe_pkg.sv @@
// ----------------------------------------------------------------------------
// mpe_pkg: shared definitions of the Mandelbrot pixel escape engine
// Field widths, register indexes and reset values, mapping constants, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mpe_pkg;

  // Default frame geometry and fixed-point format.
  localparam int WIDTH_DEF     = 320;
  localparam int HEIGHT_DEF    = 200;
  localparam int FRAC_BITS_DEF = 28;

  // Field widths of the request, result and configuration channels.
  localparam int PX_W       = 9;
  localparam int PY_W       = 8;
  localparam int ADDR_W     = 16;
  localparam int ITER_W     = 10;
  localparam int COLOR_W    = 8;
  localparam int ZOOM_W     = 16;
  localparam int CENTER_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 2'd3;

  // Reset values that do not depend on the fraction width.
  localparam logic [ZOOM_W-1:0]   ZOOM_RST      = 16'd256;
  localparam logic [CENTER_W-1:0] CENTER_IM_RST = '0;
  localparam logic [ITER_W-1:0]   MAX_ITER_RST  = 10'd300;

  // Signed pixel offset from the frame center and its magnitude.
  localparam int OFS_W     = 11;
  localparam int OFS_MAG_W = 10;

  // Axis scale factors: 1.5 and 1.0 over half a frame, with zoom/256.
  localparam int X_SCALE   = 768;
  localparam int Y_SCALE   = 512;
  localparam int MAPNUM_W  = 19;

  // Shade numerator: count times 255 fits in 18 bits.
  localparam int SHADE_MAX   = 255;
  localparam int COLOR_NUM_W = 18;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_px;
    logic div_step;
    logic load_c;
    logic iter_step;
    logic load_color;
    logic load_out;
  } mpe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic escaped;
    logic at_limit;
  } mpe_sts_t;

endpackage

@@ src/mpe_ifs.sv @@
// ----------------------------------------------------------------------------
// mpe_ifs: channel interfaces of the Mandelbrot pixel escape engine
// Pixel request channel, result channel and configuration write channel,
// each with valid and ready.
// ----------------------------------------------------------------------------
interface mpe_pix_if import mpe_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PX_W-1:0] pixel_x;
  logic [PY_W-1:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface mpe_res_if import mpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  pixel_address;
  logic [ITER_W-1:0]  iteration_count;
  logic [COLOR_W-1:0] color;

  modport source (output valid, pixel_address, iteration_count, color, input ready);
  modport sink   (input valid, pixel_address, iteration_count, color, output ready);
endinterface

interface mpe_cfg_if import mpe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ src/mpe_div_lane.sv @@
// ----------------------------------------------------------------------------
// mpe_div_lane: restoring divider, one quotient bit per cycle while step_i is high
// The dividend register shifts left and collects quotient bits at its bottom,
// so after k steps its low k bits hold the quotient of its top k bits.
// ----------------------------------------------------------------------------
module mpe_div_lane #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 25
) (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             step_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic [NUM_W-1:0] quotient_o
);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Bring down the next dividend bit and try a subtraction.
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
    rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    num_d = {num_q[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (step_i) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = num_q;

endmodule

@@ src/mpe_datapath.sv @@
// ----------------------------------------------------------------------------
// mpe_datapath: registers and arithmetic of the pixel escape engine
// Configuration registers, coordinate mapping through two divider lanes,
// the z = z*z + c iteration unit, the shade divider and the result register.
// ----------------------------------------------------------------------------
module mpe_datapath import mpe_pkg::*; #(
  parameter int WIDTH     = WIDTH_DEF,
  parameter int HEIGHT    = HEIGHT_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mpe_cmd_t              cmd_i,
  output mpe_sts_t              sts_o,
  input  logic [PX_W-1:0]       pixel_x_i,
  input  logic [PY_W-1:0]       pixel_y_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [ADDR_W-1:0]     pixel_address_o,
  output logic [ITER_W-1:0]     iteration_count_o,
  output logic [COLOR_W-1:0]    color_o
);

  localparam int NUM_W   = MAPNUM_W + FRAC_BITS;
  localparam int MAX_DIM = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
  localparam int DEN_W   = ZOOM_W + $clog2(MAX_DIM + 1);
  localparam int SUM_W   = ((NUM_W > CENTER_W) ? NUM_W : CENTER_W) + 2;
  localparam int C_W     = FRAC_BITS + 4;   // c within +-4.0
  localparam int MAG_W   = FRAC_BITS + 4;   // |z| up to 8.0
  localparam int SQ_W    = FRAC_BITS + 7;   // squares up to 64.0
  localparam int PR_W    = SQ_W + 1;        // signed cross product
  localparam int ZF_W    = FRAC_BITS + 10;  // full-width new z
  localparam int HALF_W  = WIDTH / 2;
  localparam int HALF_H  = HEIGHT / 2;

  localparam logic [CENTER_W-1:0] CENTER_RE_RST =
    CENTER_W'(-(64'sd1 <<< (FRAC_BITS - 1)));
  localparam logic signed [SUM_W-1:0] LIM  = SUM_W'(4) <<< FRAC_BITS;
  localparam logic [SQ_W:0]           FOUR = (SQ_W + 1)'(4) << FRAC_BITS;

  // Configuration registers.
  logic [ZOOM_W-1:0]   zoom_q;
  logic [CENTER_W-1:0] cre_q;
  logic [CENTER_W-1:0] cim_q;
  logic [ITER_W-1:0]   maxit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q  <= ZOOM_RST;
      cre_q   <= CENTER_RE_RST;
      cim_q   <= CENTER_IM_RST;
      maxit_q <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ZOOM:      zoom_q  <= cfg_data_i[ZOOM_W-1:0];
        REG_CENTER_RE: cre_q   <= cfg_data_i[CENTER_W-1:0];
        REG_CENTER_IM: cim_q   <= cfg_data_i[CENTER_W-1:0];
        REG_MAX_ITER:  maxit_q <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixel offsets from the frame center, split into sign and magnitude.
  logic signed [OFS_W-1:0] dx, dy;
  logic [OFS_W-1:0]        dx_abs, dy_abs;
  logic [MAPNUM_W-1:0]     mx, my;
  logic [ZOOM_W-1:0]       zoom_eff;
  logic [DEN_W-1:0]        den_x, den_y;

  always_comb begin
    dx       = $signed({2'b00, pixel_x_i}) - OFS_W'(HALF_W);
    dy       = $signed({3'b000, pixel_y_i}) - OFS_W'(HALF_H);
    dx_abs   = dx[OFS_W-1] ? OFS_W'(-dx) : OFS_W'(dx);
    dy_abs   = dy[OFS_W-1] ? OFS_W'(-dy) : OFS_W'(dy);
    mx       = MAPNUM_W'(dx_abs[OFS_MAG_W-1:0] * X_SCALE);
    my       = MAPNUM_W'(dy_abs[OFS_MAG_W-1:0] * Y_SCALE);
    zoom_eff = (zoom_q == '0) ? ZOOM_W'(1) : zoom_q;
    den_x    = DEN_W'(zoom_eff * WIDTH);
    den_y    = DEN_W'(zoom_eff * HEIGHT);
  end

  // Pixel bookkeeping latched with the request.
  logic [ADDR_W-1:0] addr_q;
  logic              neg_x_q, neg_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_px) begin
      addr_q  <= ADDR_W'(32'(pixel_y_i) * WIDTH + 32'(pixel_x_i));
      neg_x_q <= dx[OFS_W-1];
      neg_y_q <= dy[OFS_W-1];
    end
  end

  // Divider lanes: the x lane is reused for the shade after the iteration.
  logic [ITER_W-1:0]      fin_cnt;
  logic [COLOR_NUM_W-1:0] shade_num;
  logic [NUM_W-1:0]       div_x_num;
  logic [DEN_W-1:0]       div_x_den;
  logic [NUM_W-1:0]       qx, qy;

  always_comb begin
    shade_num = COLOR_NUM_W'(fin_cnt * SHADE_MAX);
    if (cmd_i.load_color) begin
      div_x_num = {shade_num, {(NUM_W - COLOR_NUM_W){1'b0}}};
      div_x_den = DEN_W'(maxit_q);
    end else begin
      div_x_num = {mx, {FRAC_BITS{1'b0}}};
      div_x_den = den_x;
    end
  end

  mpe_div_lane #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div_x (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load_px | cmd_i.load_color),
    .step_i     (cmd_i.div_step),
    .dividend_i (div_x_num),
    .divisor_i  (div_x_den),
    .quotient_o (qx)
  );

  mpe_div_lane #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div_y (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load_px),
    .step_i     (cmd_i.div_step),
    .dividend_i ({my, {FRAC_BITS{1'b0}}}),
    .divisor_i  (den_y),
    .quotient_o (qy)
  );

  // Apply the sign, add the view center and clamp each axis to +-4.0.
  logic signed [SUM_W-1:0] vx, vy, cx, cy;

  always_comb begin
    vx = (neg_x_q ? -$signed(SUM_W'(qx)) : $signed(SUM_W'(qx)))
         + SUM_W'($signed(cre_q));
    vy = (neg_y_q ? -$signed(SUM_W'(qy)) : $signed(SUM_W'(qy)))
         + SUM_W'($signed(cim_q));
    if (vx > LIM) cx = LIM;
    else if (vx < -LIM) cx = -LIM;
    else cx = vx;
    if (vy > LIM) cy = LIM;
    else if (vy < -LIM) cy = -LIM;
    else cy = vy;
  end

  // Iteration state: c, the squares and cross product of the current z.
  logic signed [C_W-1:0]  cr_q, ci_q;
  logic [SQ_W-1:0]        sr_q, si_q;
  logic signed [PR_W-1:0] pr_q;
  logic [ITER_W-1:0]      i_q;
  logic                   started_q;

  logic signed [ZF_W-1:0]  zr, zi, zr_abs, zi_abs;
  logic [MAG_W-1:0]        mag_re, mag_im;
  logic [2*MAG_W-1:0]      prod_rr, prod_ii, prod_ri;
  logic [SQ_W-1:0]         sr_d, si_d, pr_mag;
  logic signed [PR_W-1:0]  pr_d;
  logic                    pr_neg;

  // New z from the stored squares, then its squares and cross product.
  always_comb begin
    zr      = $signed({3'b000, sr_q}) - $signed({3'b000, si_q}) + ZF_W'(cr_q);
    zi      = (ZF_W'(pr_q) <<< 1) + ZF_W'(ci_q);
    zr_abs  = zr[ZF_W-1] ? -zr : zr;
    zi_abs  = zi[ZF_W-1] ? -zi : zi;
    mag_re  = zr_abs[MAG_W-1:0];
    mag_im  = zi_abs[MAG_W-1:0];
    prod_rr = mag_re * mag_re;
    prod_ii = mag_im * mag_im;
    prod_ri = mag_re * mag_im;
    sr_d    = prod_rr[FRAC_BITS +: SQ_W];
    si_d    = prod_ii[FRAC_BITS +: SQ_W];
    pr_mag  = prod_ri[FRAC_BITS +: SQ_W];
    pr_neg  = zr[ZF_W-1] ^ zi[ZF_W-1];
    pr_d    = pr_neg ? -$signed({1'b0, pr_mag}) : $signed({1'b0, pr_mag});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_c) begin
      cr_q      <= cx[C_W-1:0];
      ci_q      <= cy[C_W-1:0];
      sr_q      <= '0;
      si_q      <= '0;
      pr_q      <= '0;
      i_q       <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.iter_step) begin
      sr_q      <= sr_d;
      si_q      <= si_d;
      pr_q      <= pr_d;
      i_q       <= i_q + ITER_W'(1);
      started_q <= 1'b1;
    end
  end

  // Escape test on the squares of the last step taken.
  always_comb begin
    sts_o.escaped  = started_q && (({1'b0, sr_q} + {1'b0, si_q}) > FOUR);
    sts_o.at_limit = (i_q == maxit_q);
    fin_cnt        = sts_o.escaped ? (i_q - ITER_W'(1)) : i_q;
  end

  // Final count, kept while the shade is divided out.
  logic [ITER_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_color) begin
      cnt_q <= fin_cnt;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pixel_address_o   <= addr_q;
      iteration_count_o <= cnt_q;
      color_o           <= (maxit_q == '0) ? '0 : qx[COLOR_W-1:0];
    end
  end

endmodule

@@ src/mpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpe_ctrl: sequencer of the pixel escape engine
// Steps one pixel through mapping division, iteration, shade division and
// hand-off to the result register, and owns the result valid flag.
// ----------------------------------------------------------------------------
module mpe_ctrl import mpe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  mpe_sts_t sts_i,
  output mpe_cmd_t cmd_o
);

  localparam int NUM_W = MAPNUM_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MAP   = 3'd2;
  localparam logic [2:0] S_ITER  = 3'd3;
  localparam logic [2:0] S_COLOR = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_px = 1'b1;
          cnt_d         = CNT_W'(NUM_W - 1);
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_MAP;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_MAP: begin
        cmd_o.load_c = 1'b1;
        state_d      = S_ITER;
      end
      S_ITER: begin
        if (sts_i.escaped || sts_i.at_limit) begin
          cmd_o.load_color = 1'b1;
          cnt_d            = CNT_W'(COLOR_NUM_W - 1);
          state_d          = S_COLOR;
        end else begin
          cmd_o.iter_step = 1'b1;
        end
      end
      S_COLOR: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid: set when the result register loads, cleared when taken.
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/mandelbrot_pixel_escape.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_pixel_escape: escape-time engine for one pixel per request
// Maps a pixel to a point c, iterates z = z*z + c and returns the frame
// buffer offset, the escape index and a grey shade.
// ----------------------------------------------------------------------------
// A request passes through three parts of the sequence. The two coordinate
// divisions of NUM_W = 19 + FRAC_BITS bits (47 by default) run side by side
// at one quotient bit per cycle; the iteration unit runs one step of
// z = z*z + c per cycle on three parallel multipliers, at most max_iterations
// steps (300 by default); and the shade division reuses a divider lane.
// One request is in work at a time; the result register lets the next
// request enter while a result still waits to be taken. Configuration
// writes are accepted in every cycle and must only be issued while the
// engine is idle.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape import mpe_pkg::*; #(
  parameter int WIDTH     = WIDTH_DEF,
  parameter int HEIGHT    = HEIGHT_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mpe_pix_if.sink   pix_in_i,
  mpe_res_if.source pix_out_o,
  mpe_cfg_if.sink   cfg_i
);

  mpe_cmd_t cmd;
  mpe_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  // Configuration writes never stall.
  assign cfg_i.ready = 1'b1;

  assign pix_in_i.ready  = in_ready;
  assign pix_out_o.valid = out_valid;

  mpe_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (pix_out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mpe_datapath #(
    .WIDTH     (WIDTH),
    .HEIGHT    (HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .pixel_x_i         (pix_in_i.pixel_x),
    .pixel_y_i         (pix_in_i.pixel_y),
    .cfg_we_i          (cfg_i.valid),
    .cfg_idx_i         (cfg_i.reg_index),
    .cfg_data_i        (cfg_i.wr_data),
    .pixel_address_o   (pix_out_o.pixel_address),
    .iteration_count_o (pix_out_o.iteration_count),
    .color_o           (pix_out_o.color)
  );

endmodule

@@ test/mandelbrot_pixel_escape_tb.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_pixel_escape_tb: self-checking bench of the pixel escape engine
// A queue of pixel requests feeds a clocked driver, and the engine's view
// registers are rewritten between phases while the engine is idle. Each
// accepted request is run through an escape-time model of the engine, and the
// results are compared field by field, in order, with what the engine returns.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape_tb import mpe_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FB            = FRAC_BITS_DEF;
  localparam longint ESCAPE_RADIUS = longint'(4) <<< FB;
  localparam longint AXIS_LIMIT    = longint'(4) <<< FB;
  localparam int     SETTLE_CYCLES = 120;
  localparam int     STALL_LIMIT   = 10000;

  typedef struct packed {
    logic [PX_W-1:0] px;
    logic [PY_W-1:0] py;
  } pixel_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [ITER_W-1:0]  count;
    logic [COLOR_W-1:0] shade;
  } escape_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } view_write_t;

  logic clk_i;
  logic rst_ni;

  mpe_pix_if pix_bus ();
  mpe_res_if res_bus ();
  mpe_cfg_if cfg_bus ();

  mandelbrot_pixel_escape uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_in_i  (pix_bus),
    .pix_out_o (res_bus),
    .cfg_i     (cfg_bus)
  );

  pixel_req_t     pending_pixels[$];
  view_write_t    pending_writes[$];
  escape_result_t expected_escapes[$];

  // Shadow copy of the view registers, updated as writes are accepted.
  logic [ZOOM_W-1:0]   view_zoom;
  logic [CENTER_W-1:0] view_re;
  logic [CENTER_W-1:0] view_im;
  logic [ITER_W-1:0]   iter_limit;

  int unsigned idle_pct;
  int unsigned src_gap;
  int unsigned snk_gap;
  int unsigned quiet_cycles;
  int unsigned fail_count = 0;

  // Signed fixed-point product, truncated toward zero.
  function automatic longint fx_mul(longint a, longint b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] p;
    longint       r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = {64'd0, ma} * {64'd0, mb};
    r  = longint'({1'b0, p[FB+62:FB]});
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // Maps a pixel offset onto one axis of the plane and clamps far points.
  function automatic longint map_axis_pt(longint d, longint scale, longint den,
                                         longint center);
    longint num;
    longint q;
    longint v;
    num = ((d < 0) ? -d : d) * scale;
    num = num <<< FB;
    q   = num / den;
    v   = ((d < 0) ? -q : q) + center;
    if (v > AXIS_LIMIT) v = AXIS_LIMIT;
    if (v < -AXIS_LIMIT) v = -AXIS_LIMIT;
    return v;
  endfunction

  // Escape-time result of one pixel under the current view.
  function automatic escape_result_t predict_escape(pixel_req_t req);
    longint         zm;
    longint         cr;
    longint         ci;
    longint         zr;
    longint         zi;
    longint         sr;
    longint         si;
    longint         nr;
    longint         ni;
    int unsigned    n;
    bit             escaped;
    escape_result_t r;
    zm = (view_zoom == '0) ? 1 : longint'(view_zoom);
    cr = map_axis_pt(longint'(req.px) - WIDTH_DEF / 2, X_SCALE, zm * WIDTH_DEF,
                     longint'($signed(view_re)));
    ci = map_axis_pt(longint'(req.py) - HEIGHT_DEF / 2, Y_SCALE, zm * HEIGHT_DEF,
                     longint'($signed(view_im)));
    zr = 0;
    zi = 0;
    sr = 0;
    si = 0;
    n = 0;
    escaped = 1'b0;
    while (n < iter_limit && !escaped) begin
      nr = sr - si + cr;
      ni = 2 * fx_mul(zr, zi) + ci;
      zr = nr;
      zi = ni;
      sr = fx_mul(zr, zr);
      si = fx_mul(zi, zi);
      if (sr + si > ESCAPE_RADIUS) escaped = 1'b1;
      else n++;
    end
    r.addr  = ADDR_W'(int'(req.py) * WIDTH_DEF + int'(req.px));
    r.count = ITER_W'(n);
    r.shade = (iter_limit == '0) ? '0 : COLOR_W'((n * SHADE_MAX) / iter_limit);
    return r;
  endfunction

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Pixel request driver, with random bursts of idle cycles between requests.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_bus.valid   <= 1'b0;
      pix_bus.pixel_x <= '0;
      pix_bus.pixel_y <= '0;
      src_gap <= 0;
    end else if (!pix_bus.valid || pix_bus.ready) begin
      if (src_gap != 0) begin
        pix_bus.valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (pending_pixels.size() != 0) begin
        pixel_req_t req;
        req = pending_pixels.pop_front();
        pix_bus.valid   <= 1'b1;
        pix_bus.pixel_x <= req.px;
        pix_bus.pixel_y <= req.py;
        if ($urandom_range(99, 0) < idle_pct) src_gap <= $urandom_range(7, 1);
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  // Result ready, with random stall bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      snk_gap <= 0;
    end else if (snk_gap != 0) begin
      res_bus.ready <= 1'b0;
      snk_gap <= snk_gap - 1;
    end else begin
      res_bus.ready <= 1'b1;
      if ($urandom_range(99, 0) < idle_pct) snk_gap <= $urandom_range(7, 1);
    end
  end

  // View register write driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg_bus.valid     <= 1'b0;
      cfg_bus.reg_index <= REG_ZOOM;
      cfg_bus.wr_data   <= '0;
    end else if (!cfg_bus.valid || cfg_bus.ready) begin
      if (pending_writes.size() != 0) begin
        view_write_t w;
        w = pending_writes.pop_front();
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= w.idx;
        cfg_bus.wr_data   <= w.data;
      end else begin
        cfg_bus.valid <= 1'b0;
      end
    end
  end

  // Track the view registers as the engine sees them.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      view_zoom  <= ZOOM_RST;
      view_re    <= CENTER_W'(-(longint'(1) <<< (FB - 1)));
      view_im    <= CENTER_IM_RST;
      iter_limit <= MAX_ITER_RST;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.reg_index)
        REG_ZOOM:      view_zoom  <= cfg_bus.wr_data[ZOOM_W-1:0];
        REG_CENTER_RE: view_re    <= cfg_bus.wr_data[CENTER_W-1:0];
        REG_CENTER_IM: view_im    <= cfg_bus.wr_data[CENTER_W-1:0];
        REG_MAX_ITER:  iter_limit <= cfg_bus.wr_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Each accepted request adds its expected result.
  always @(posedge clk_i) begin
    if (rst_ni && pix_bus.valid && pix_bus.ready) begin
      expected_escapes.push_back(predict_escape('{pix_bus.pixel_x, pix_bus.pixel_y}));
    end
  end

  // Compare each returned result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      escape_result_t e;
      if (expected_escapes.size() == 0) begin
        $error("unexpected result at pixel_address %0d", res_bus.pixel_address);
        fail_count++;
      end else begin
        e = expected_escapes.pop_front();
        if (res_bus.pixel_address !== e.addr) begin
          $error("pixel_address: expected %0d, got %0d", e.addr, res_bus.pixel_address);
          fail_count++;
        end
        if (res_bus.iteration_count !== e.count) begin
          $error("iteration_count: expected %0d, got %0d", e.count,
                 res_bus.iteration_count);
          fail_count++;
        end
        if (res_bus.color !== e.shade) begin
          $error("color: expected %0d, got %0d", e.shade, res_bus.color);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any request moving on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
                 (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL mandelbrot_pixel_escape");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_pixel(int unsigned x, int unsigned y);
    pending_pixels.push_back('{PX_W'(x), PY_W'(y)});
  endtask

  // Mostly pixels inside the frame, some anywhere the fields reach.
  task automatic queue_random_pixels(int unsigned count);
    repeat (count) begin
      if ($urandom_range(99, 0) < 85) begin
        queue_pixel($urandom_range(WIDTH_DEF - 1, 0), $urandom_range(HEIGHT_DEF - 1, 0));
      end else begin
        queue_pixel($urandom, $urandom);
      end
    end
  endtask

  // Wait until every request has been taken and answered, then let it settle.
  task automatic drain_pixels();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || pix_bus.valid || expected_escapes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Rewrite the whole view; only called while the engine is idle.
  task automatic write_view(logic [ZOOM_W-1:0] zoom, logic [CENTER_W-1:0] re,
                            logic [CENTER_W-1:0] im, logic [ITER_W-1:0] limit);
    pending_writes.push_back('{REG_ZOOM, CFG_DATA_W'(zoom)});
    pending_writes.push_back('{REG_CENTER_RE, CFG_DATA_W'(re)});
    pending_writes.push_back('{REG_CENTER_IM, CFG_DATA_W'(im)});
    pending_writes.push_back('{REG_MAX_ITER, CFG_DATA_W'(limit)});
    do @(negedge clk_i);
    while (pending_writes.size() != 0 || cfg_bus.valid);
  endtask

  // Reset, then directed phases followed by random ones.
  initial begin
    rst_ni = 1'b0;
    idle_pct = 40;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset view: frame corners, the center point and pixels off the frame.
    queue_pixel(0, 0);
    queue_pixel(WIDTH_DEF - 1, HEIGHT_DEF - 1);
    queue_pixel(WIDTH_DEF - 1, 0);
    queue_pixel(0, HEIGHT_DEF - 1);
    queue_pixel(WIDTH_DEF / 2, HEIGHT_DEF / 2);
    queue_pixel(511, 255);
    queue_pixel(WIDTH_DEF, HEIGHT_DEF);
    queue_pixel(0, HEIGHT_DEF / 2);
    queue_pixel(255, 127);
    queue_pixel(80, 50);
    queue_pixel(200, 100);
    queue_pixel(240, 100);
    drain_pixels();

    // Zero zoom with extreme centers and a zero iteration limit.
    write_view('0, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    queue_pixel(0, 0);
    queue_pixel(511, 255);
    queue_pixel(WIDTH_DEF / 2, HEIGHT_DEF / 2);
    drain_pixels();

    // Deepest zoom near the set boundary at the largest limit.
    write_view(16'hFFFF, CENTER_W'(-201326592), CENTER_W'(26843546), 10'd1023);
    queue_pixel(WIDTH_DEF / 2, HEIGHT_DEF / 2);
    queue_pixel(0, 0);
    queue_pixel(WIDTH_DEF - 1, HEIGHT_DEF - 1);
    queue_pixel(WIDTH_DEF / 2 + 1, HEIGHT_DEF / 2);
    drain_pixels();

    // Far point in the other corner of the plane, limit of one step.
    write_view(ZOOM_RST, 32'h7FFF_FFFF, 32'h8000_0000, 10'd1);
    queue_pixel(WIDTH_DEF / 2, HEIGHT_DEF / 2);
    queue_pixel(0, 0);
    queue_pixel(WIDTH_DEF - 1, HEIGHT_DEF - 1);
    drain_pixels();

    // Whole set in view at the default limit.
    idle_pct = 30;
    write_view(ZOOM_RST, CENTER_W'(-134217728), '0, MAX_ITER_RST);
    queue_random_pixels(300);
    drain_pixels();

    // Moderate zooms onto random points of the boundary region.
    idle_pct = 60;
    write_view(ZOOM_W'($urandom_range(4096, 256)),
               CENTER_W'(int'($urandom_range(671088640, 0)) - 536870912),
               CENTER_W'(int'($urandom_range(536870912, 0)) - 268435456),
               ITER_W'($urandom_range(128, 16)));
    queue_random_pixels(300);
    drain_pixels();

    // Anything the registers allow.
    idle_pct = 20;
    write_view(ZOOM_W'($urandom_range(65535, 1)), CENTER_W'($urandom),
               CENTER_W'($urandom), ITER_W'($urandom_range(1023, 1)));
    queue_random_pixels(200);
    drain_pixels();

    // Largest limit over the whole set.
    idle_pct = 0;
    write_view(ZOOM_RST, CENTER_W'(-134217728), '0, 10'd1023);
    queue_random_pixels(60);
    drain_pixels();

    // Single step at the deepest zoom.
    idle_pct = 50;
    write_view(16'hFFFF, CENTER_W'(int'($urandom_range(671088640, 0)) - 536870912),
               '0, 10'd1);
    queue_random_pixels(150);
    drain_pixels();

    // Closing stretch at full rate on both sides.
    idle_pct = 0;
    write_view(16'd512, CENTER_W'(-201326592), '0, 10'd64);
    queue_random_pixels(200);
    drain_pixels();

    if (fail_count == 0) begin
      $display("PASS mandelbrot_pixel_escape");
    end else begin
      $display("FAIL mandelbrot_pixel_escape");
    end
    $finish;
  end

endmodule

@@ mandelbrot_pixel_escape.f @@
src/mpe_pkg.sv
src/mpe_ifs.sv
src/mpe_div_lane.sv
src/mpe_datapath.sv
src/mpe_ctrl.sv
src/mandelbrot_pixel_escape.sv
test/mandelbrot_pixel_escape_tb.sv
